/* hdl/aisp_pkg.sv */
// Shared types and constants for the altitude filter, speed and peak block.
// No dependencies; imported by every module of the block.
package aisp_pkg;

   localparam int DATA_W    = 24;
   localparam int COEF_W    = 18;
   localparam int DELTA_W   = DATA_W + 1;
   localparam int SPEED_W   = 23;
   localparam int IDX_W     = 3;
   localparam int RSP_DATA_W = 72;

   // register indexes
   localparam logic [IDX_W-1:0] REG_LOW_LIMIT   = 3'd0;
   localparam logic [IDX_W-1:0] REG_HIGH_LIMIT  = 3'd1;
   localparam logic [IDX_W-1:0] REG_FEED_0      = 3'd2;
   localparam logic [IDX_W-1:0] REG_FEED_1      = 3'd3;
   localparam logic [IDX_W-1:0] REG_FEED_2      = 3'd4;
   localparam logic [IDX_W-1:0] REG_FEEDBACK_1  = 3'd5;
   localparam logic [IDX_W-1:0] REG_FEEDBACK_2  = 3'd6;

   localparam logic signed [DATA_W-1:0] LOW_LIMIT_RST  = -24'sd128000;
   localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RST = 24'sd2560000;
   localparam logic signed [COEF_W-1:0] FEED_0_RST     = 18'sd65536;

   localparam logic signed [DATA_W-1:0] ALT_MAX = 24'sh7FFFFF;
   localparam logic signed [DATA_W-1:0] ALT_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [DATA_W-1:0] low_limit;
      logic signed [DATA_W-1:0] high_limit;
      logic [2:0][COEF_W-1:0]   feed_coef;      // b0..b2
      logic [2:1][COEF_W-1:0]   feedback_coef;  // a1..a2
   } cfg_type;

   typedef struct packed {
      logic                     sample_valid;
      logic signed [DATA_W-1:0] filtered;
      logic [DELTA_W-1:0]       delta;
      logic [SPEED_W-1:0]       peak;
   } mid_type;

endpackage

/* hdl/aisp_csr.sv */
// Configuration registers: limits and filter coefficients, write only.
// Depends on aisp_pkg.
module aisp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [aisp_pkg::IDX_W-1:0]         csr_index,
   input  logic [aisp_pkg::DATA_W-1:0]        csr_wdata,
   output aisp_pkg::cfg_type                  cfg
);
   import aisp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_LOW_LIMIT:  cfg_in.low_limit        = csr_wdata;
            REG_HIGH_LIMIT: cfg_in.high_limit       = csr_wdata;
            REG_FEED_0:     cfg_in.feed_coef[0]     = csr_wdata[COEF_W-1:0];
            REG_FEED_1:     cfg_in.feed_coef[1]     = csr_wdata[COEF_W-1:0];
            REG_FEED_2:     cfg_in.feed_coef[2]     = csr_wdata[COEF_W-1:0];
            REG_FEEDBACK_1: cfg_in.feedback_coef[1] = csr_wdata[COEF_W-1:0];
            REG_FEEDBACK_2: cfg_in.feedback_coef[2] = csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit        <= LOW_LIMIT_RST;
         cfg_ff.high_limit       <= HIGH_LIMIT_RST;
         cfg_ff.feed_coef[0]     <= FEED_0_RST;
         cfg_ff.feed_coef[1]     <= '0;
         cfg_ff.feed_coef[2]     <= '0;
         cfg_ff.feedback_coef[1] <= '0;
         cfg_ff.feedback_coef[2] <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/aisp_filter_core.sv */
// Filter stage: limit check, IIR multiply-accumulate with rounding and saturation,
// raw and filtered histories, peak tracking and delta magnitude. Depends on aisp_pkg.
module aisp_filter_core #(
   parameter int FILTER_TAPS = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic signed [aisp_pkg::DATA_W-1:0] sample,
   input  aisp_pkg::cfg_type                  cfg,
   output aisp_pkg::mid_type                  mid_in
);
   import aisp_pkg::*;

   localparam int HIST   = FILTER_TAPS - 1;
   localparam int PROD_W = COEF_W + DATA_W;
   localparam int ACC_W  = PROD_W + 6;
   localparam int PRE_W  = ACC_W - 16;

   logic signed [DATA_W-1:0] raw_ff    [HIST];
   logic signed [DATA_W-1:0] raw_in    [HIST];
   logic signed [DATA_W-1:0] smooth_ff [HIST];
   logic signed [DATA_W-1:0] smooth_in [HIST];
   logic signed [DATA_W-1:0] peak_ff, peak_in;

   logic                      in_window;
   logic signed [ACC_W-1:0]   acc;
   logic signed [PRE_W-1:0]   pre;
   logic signed [DATA_W-1:0]  y0;
   logic signed [DELTA_W-1:0] diff;
   logic [DELTA_W-1:0]        mag;

   always_comb begin
      logic signed [PROD_W-1:0] p_ff;
      logic signed [PROD_W-1:0] p_fb;
      in_window = !(sample < cfg.low_limit) && !(sample > cfg.high_limit);
      p_ff = $signed(cfg.feed_coef[0]) * sample;
      acc  = ACC_W'(p_ff);
      for (int i = 1; i < FILTER_TAPS && i < 3; i++) begin
         p_ff = $signed(cfg.feed_coef[i]) * raw_ff[i-1];
         p_fb = $signed(cfg.feedback_coef[i]) * smooth_ff[i-1];
         acc  = acc + ACC_W'(p_ff) - ACC_W'(p_fb);
      end
      // round half up to Q16.8, then saturate
      pre = PRE_W'((acc + ACC_W'(32768)) >>> 16);
      if (pre > PRE_W'(ALT_MAX))
         y0 = ALT_MAX;
      else if (pre < PRE_W'(ALT_MIN))
         y0 = ALT_MIN;
      else
         y0 = pre[DATA_W-1:0];
      diff = DELTA_W'(y0) - DELTA_W'(smooth_ff[HIST-1]);
      mag  = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);
   end

   always_comb begin
      raw_in[0]    = sample;
      smooth_in[0] = y0;
      for (int i = 1; i < HIST; i++) begin
         raw_in[i]    = raw_ff[i-1];
         smooth_in[i] = smooth_ff[i-1];
      end
      peak_in = (in_window && (y0 > peak_ff)) ? y0 : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST; i++) begin
            raw_ff[i]    <= '0;
            smooth_ff[i] <= '0;
         end
         peak_ff <= '0;
      end else if (advance && in_window) begin
         raw_ff    <= raw_in;
         smooth_ff <= smooth_in;
         peak_ff   <= peak_in;
      end
   end

   always_comb begin
      mid_in.sample_valid = in_window;
      mid_in.filtered     = in_window ? y0 : '0;
      mid_in.delta        = in_window ? mag : '0;
      mid_in.peak         = peak_in[SPEED_W-1:0];
   end

endmodule

/* hdl/aisp_speed_div.sv */
// Speed stage: rounded division of the altitude change by the history depth,
// by a reciprocal multiply, then saturation. Depends on aisp_pkg.
module aisp_speed_div #(
   parameter int FILTER_TAPS = 3
) (
   input  logic [aisp_pkg::DELTA_W-1:0] delta,
   output logic [aisp_pkg::SPEED_W-1:0] speed
);
   import aisp_pkg::*;

   localparam int DIV   = FILTER_TAPS - 1;
   localparam int SHIFT = DELTA_W + $clog2(DIV);
   localparam int RCP_W = DELTA_W + 1;
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam int PRD_W = DELTA_W + RCP_W;

   logic [DELTA_W-1:0] num;
   logic [RCP_W-1:0]   recip;
   logic [PRD_W-1:0]   prod;
   logic [DELTA_W-1:0] quot;

   always_comb begin
      num   = delta + DELTA_W'(DIV / 2);
      recip = RCP_W'(RECIP);
      prod  = PRD_W'(num) * PRD_W'(recip);
      quot  = DELTA_W'(prod >> SHIFT);
      if (quot > DELTA_W'(ALT_MAX))
         speed = SPEED_W'(ALT_MAX);
      else
         speed = quot[SPEED_W-1:0];
   end

endmodule

/* hdl/altitude_iir_speed_peak.sv */
// Top level: altitude IIR low-pass with vertical speed and peak tracking.
// Depends on aisp_pkg, aisp_csr, aisp_filter_core and aisp_speed_div.
//
//   port group | dir | word contents
//   req_*      | in  | tdata[23:0] altitude sample
//   rsp_*      | out | tuser sample valid; tdata filtered, speed, peak
//   csr_*      | in  | index 0..6, write only
//
// One word per cycle sustained while rsp_tready is high; a req word passes the input
// register, filter stage and speed/result register before rsp_tvalid rises. The filter
// feedback closes through the history registers. Reset clears the histories, the peak
// and the stage valid flags and loads the register defaults.
// A stalled rsp backs up the three stages, then req_tready drops.
module altitude_iir_speed_peak #(
   parameter int FILTER_TAPS = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [aisp_pkg::DATA_W-1:0]            req_tdata,   // [23:0] altitude_sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [aisp_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // filtered, speed, peak
   output logic                                   rsp_tuser,   // [0] sample_valid
   input  logic                                   csr_wr_en,
   input  logic [aisp_pkg::IDX_W-1:0]             csr_index,
   input  logic [aisp_pkg::DATA_W-1:0]            csr_wdata
);
   import aisp_pkg::*;

   cfg_type cfg;

   logic                     in_valid_ff, in_valid_in;
   logic signed [DATA_W-1:0] in_sample_ff;
   logic                     mid_valid_ff, mid_valid_in;
   mid_type                  mid_ff, mid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_sv_ff;
   logic signed [DATA_W-1:0] rsp_filt_ff;
   logic [SPEED_W-1:0]       rsp_speed_ff;
   logic [SPEED_W-1:0]       rsp_peak_ff;
   logic [SPEED_W-1:0]       speed;

   logic out_free, mid_free, in_free, core_adv;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign mid_free = !mid_valid_ff || out_free;
   assign in_free  = !in_valid_ff || mid_free;
   assign core_adv = in_valid_ff && mid_free;

   assign req_tready = in_free;

   aisp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aisp_filter_core #(.FILTER_TAPS(FILTER_TAPS)) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (core_adv),
      .sample  (in_sample_ff),
      .cfg     (cfg),
      .mid_in  (mid_in)
   );

   aisp_speed_div #(.FILTER_TAPS(FILTER_TAPS)) u_div (
      .delta (mid_ff.delta),
      .speed (speed)
   );

   always_comb begin
      in_valid_in  = in_free ? req_tvalid : in_valid_ff;
      mid_valid_in = mid_free ? in_valid_ff : mid_valid_ff;
      rsp_valid_in = out_free ? mid_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free)
         in_sample_ff <= req_tdata;
      if (mid_free)
         mid_ff <= mid_in;
      if (out_free) begin
         rsp_sv_ff    <= mid_ff.sample_valid;
         rsp_filt_ff  <= mid_ff.filtered;
         rsp_speed_ff <= mid_ff.sample_valid ? speed : '0;
         rsp_peak_ff  <= mid_ff.peak;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sv_ff;
   assign rsp_tdata  = {2'b00, rsp_peak_ff, rsp_speed_ff, rsp_filt_ff};

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[46:0] == 47'd0)
      else $error("rejected word carries non-zero altitude or speed");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && !rsp_tdata[23] |-> rsp_tdata[69:47] >= rsp_tdata[22:0])
      else $error("peak below filtered altitude");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && !out_free |=> mid_valid_ff && $stable(mid_ff))
      else $error("filter stage word lost under stall");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !mid_free |=> in_valid_ff && $stable(in_sample_ff))
      else $error("input word lost under stall");

endmodule
